// ===== rtl/core/length_prefixed_frame_deframer_core_macros.svh =====
// Assertion helpers for the deframer core.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_CORE_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, checked on clk outside reset.
`define LPFD_ASSERT_SAME(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define LPFD_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/core/lpfd_pkg.sv =====
package lpfd_pkg;

  localparam int STORE_DEPTH_DEF  = 64;
  localparam int RESYNC_LIMIT_DEF = 128;
  localparam int MAX_RESULTS      = 64;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;

  localparam logic [BYTE_W-1:0] HEAD_RST      = 8'hAA;
  localparam logic [BYTE_W-1:0] TAIL_RST      = 8'h55;
  localparam logic [LEN_W-1:0]  MAX_FRAME_RST = 7'd64;

  // Register map, one word each
  typedef enum logic [1:0] {
    REG_HEAD      = 2'd0,
    REG_TAIL      = 2'd1,
    REG_MAX_FRAME = 2'd2
  } reg_idx_t;

  // Frame hand-off from assembler to readout
  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] length;
  } emit_req_t;

endpackage

// ===== rtl/core/length_prefixed_frame_deframer_core.sv =====
// Deframer: head, 16-bit LE length, payload, tail. One rx byte per cycle while idle.
// A passing frame is read out of the frame store one byte per cycle unless the
// output stalls; the tail sets the busy flag, then the first store read registers
// the first byte and its valid. Input stalls while the store is read.
// Reset (rst_n, synchronous, active low) clears byte count, readout and registers
// to their defaults; the frame store is not cleared (only written entries are read).
`include "length_prefixed_frame_deframer_core_macros.svh"

module length_prefixed_frame_deframer_core
  import lpfd_pkg::*;
#(
  parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
  parameter int RESYNC_LIMIT = RESYNC_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // rx bytes
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_rx_byte,
  // frame bytes
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_frame_byte,
  output logic [LEN_W-1:0]  out_frame_length,
  output logic              out_frame_last
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // ---- configuration registers ----
  logic [BYTE_W-1:0] head_r;
  logic [BYTE_W-1:0] tail_r;
  logic [LEN_W-1:0]  max_frame_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);   // byte address 4*i, low bits ignored

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= HEAD_RST;
      tail_r      <= TAIL_RST;
      max_frame_r <= MAX_FRAME_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_HEAD:      head_r      <= pwdata[BYTE_W-1:0];
        REG_TAIL:      tail_r      <= pwdata[BYTE_W-1:0];
        REG_MAX_FRAME: max_frame_r <= pwdata[LEN_W-1:0];
        default: ;     // unmapped slot, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_HEAD:      prdata = {24'd0, head_r};
      REG_TAIL:      prdata = {24'd0, tail_r};
      REG_MAX_FRAME: prdata = {25'd0, max_frame_r};
      default:       prdata = '0;
    endcase
  end

  // ---- datapath ----
  logic              busy;
  logic              in_accept;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  emit_req_t         emit_req;

  // input holds off only while the store is being read out
  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;

  lpfd_assembler #(
    .STORE_DEPTH  (STORE_DEPTH),
    .RESYNC_LIMIT (RESYNC_LIMIT)
  ) u_asm (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .rx_byte   (in_rx_byte),
    .head_byte (head_r),
    .tail_byte (tail_r),
    .max_frame (max_frame_r),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .emit_req  (emit_req)
  );

  // frame store: written by the assembler, read by the emitter; never both on
  // a live entry since input is stalled during readout
  lpfd_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (out_frame_byte)
  );

  lpfd_emitter #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .emit_req         (emit_req),
    .out_stall        (out_stall),
    .busy             (busy),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .out_valid        (out_valid),
    .out_frame_length (out_frame_length),
    .out_frame_last   (out_frame_last)
  );

  // ---- checks ----
  `LPFD_ASSERT_NEXT(a_start_stalls, emit_req.start, in_stall, "readout did not start")
  `LPFD_ASSERT_SAME(a_rd_in_stall, rd_en, in_stall, "store read while input open")
  `LPFD_ASSERT_SAME(a_stall_cause, $rose(in_stall), $past(in_accept), "stall without accept")

endmodule

// ===== rtl/core/lpfd_store.sv =====
module lpfd_store
  import lpfd_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [STORE_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read, so a stalled item stays put
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/lpfd_assembler.sv =====
module lpfd_assembler
  import lpfd_pkg::*;
#(
  parameter int STORE_DEPTH  = STORE_DEPTH_DEF,
  parameter int RESYNC_LIMIT = RESYNC_LIMIT_DEF,
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1,
  localparam int CW = $clog2(RESYNC_LIMIT)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [BYTE_W-1:0] head_byte,
  input  logic [BYTE_W-1:0] tail_byte,
  input  logic [LEN_W-1:0]  max_frame,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [BYTE_W-1:0] wr_data,
  output emit_req_t         emit_req
);

  localparam int EMIT_CAP = (STORE_DEPTH < MAX_RESULTS) ? STORE_DEPTH : MAX_RESULTS;

  logic [CW-1:0]     count_r, count_nxt;
  logic [BYTE_W-1:0] len_lo_r, len_lo_nxt;
  logic [15:0]       need_r, need_nxt;
  logic [CW:0]       cnt_inc;
  logic [16:0]       need_sum;
  logic              complete;
  logic              fits;

  assign cnt_inc  = {1'b0, count_r} + (CW+1)'(1);
  assign need_sum = {1'b0, rx_byte, len_lo_r} + 17'd4;
  assign complete = 32'(cnt_inc) >= 32'(need_r);
  assign fits     = (need_r <= {9'd0, max_frame}) && (32'(need_r) <= 32'(EMIT_CAP));

  assign wr_en   = accept && (32'(count_r) < 32'(STORE_DEPTH));
  assign wr_addr = AW'(count_r);
  assign wr_data = rx_byte;

  always_comb begin
    count_nxt       = count_r;
    len_lo_nxt      = len_lo_r;
    need_nxt        = need_r;
    emit_req.start  = 1'b0;
    emit_req.length = need_r[LEN_W-1:0];
    if (accept) begin
      priority if (count_r == '0) begin
        // first byte must be the head, otherwise drop it
        count_nxt = (rx_byte == head_byte) ? CW'(1) : '0;
      end else if (32'(cnt_inc) == 32'd2) begin
        len_lo_nxt = rx_byte;
        count_nxt  = CW'(2);
      end else if (32'(cnt_inc) == 32'd3) begin
        // length+4 wrapping 16 bits abandons the frame
        need_nxt  = need_sum[15:0];
        count_nxt = need_sum[16] ? '0 : CW'(3);
      end else if (complete) begin
        emit_req.start = (rx_byte == tail_byte) && fits;
        count_nxt      = '0;
      end else if (32'(cnt_inc) >= 32'(RESYNC_LIMIT)) begin
        count_nxt = '0;
      end else begin
        count_nxt = CW'(cnt_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_lo_r <= len_lo_nxt;
    need_r   <= need_nxt;
  end

endmodule

// ===== rtl/core/lpfd_emitter.sv =====
module lpfd_emitter
  import lpfd_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  emit_req_t        emit_req,
  input  logic             out_stall,
  output logic             busy,
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  output logic             out_valid,
  output logic [LEN_W-1:0] out_frame_length,
  output logic             out_frame_last
);

  logic             busy_r;
  logic [LEN_W-1:0] idx_r;
  logic [LEN_W-1:0] len_r;
  logic             valid_r;
  logic [LEN_W-1:0] olen_r;
  logic             olast_r;
  logic             last_issue;

  assign rd_en      = busy_r && (!valid_r || !out_stall);
  assign rd_addr    = AW'(idx_r);
  assign last_issue = idx_r == (len_r - LEN_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (emit_req.start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (rd_en) begin
        idx_r <= idx_r + LEN_W'(1);
        if (last_issue) begin
          busy_r <= 1'b0;
        end
      end
      if (rd_en) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_req.start) begin
      len_r <= emit_req.length;
    end
    if (rd_en) begin
      olen_r  <= len_r;
      olast_r <= last_issue;
    end
  end

  assign busy             = busy_r;
  assign out_valid        = valid_r;
  assign out_frame_length = olen_r;
  assign out_frame_last   = olast_r;

endmodule

// ===== tb/length_prefixed_frame_deframer_core_tb.sv =====
`timescale 1ns / 100ps

module length_prefixed_frame_deframer_core_tb;
  import lpfd_pkg::*;

  // Longest stretch with no accepted item, APB access or result before the run is
  // declared hung. Worst legal stretch is a settle pause plus one sender gap and
  // one receiver stall.
  localparam int HANG_LIMIT   = 2000;
  localparam int SETTLE       = 12;
  localparam int STORE_DEPTH  = STORE_DEPTH_DEF;
  localparam int RESYNC_LIMIT = RESYNC_LIMIT_DEF;

  // One byte of an emitted frame as it should leave the block
  typedef struct {
    logic [BYTE_W-1:0] fbyte;
    logic [LEN_W-1:0]  flen;
    logic              flast;
  } frame_beat_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_frame_byte;
  logic [LEN_W-1:0]  out_frame_length;
  logic              out_frame_last;

  length_prefixed_frame_deframer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_frame_length (out_frame_length),
    .out_frame_last   (out_frame_last)
  );

  // ---------------------------------------------------------------------------
  // Deframer shadow: its own copy of the registers, frame store and byte count
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] head_reg = HEAD_RST;
  logic [BYTE_W-1:0] tail_reg = TAIL_RST;
  logic [LEN_W-1:0]  max_reg  = MAX_FRAME_RST;
  logic [BYTE_W-1:0] store_img [STORE_DEPTH];
  int unsigned       rx_count = 0;

  frame_beat_t pending_beats [$];

  int error_count  = 0;
  int items_sent   = 0;
  int frames_seen  = 0;
  int beats_seen   = 0;
  int reg_writes   = 0;
  int idle_cycles  = 0;
  int in_gap_max   = 8;   // sender idle draw, 0 gives back-to-back items
  int out_gap_max  = 8;   // receiver stall draw
  int hold_left    = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // Advance the shadow by one received byte and queue any frame it completes.
  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    int unsigned need;
    int unsigned cap;
    frame_beat_t beat;
    if (rx_count < STORE_DEPTH) store_img[rx_count] = b;
    rx_count++;
    // first byte must be the head byte, anything else is dropped
    if (rx_count == 1) begin
      if (b != head_reg) rx_count = 0;
      return;
    end
    if (rx_count < 3) return;
    need = int'({store_img[2], store_img[1]}) + 4;
    // length+4 does not fit 16 bits: give up right after the length bytes
    if (need > 16'hFFFF) begin
      rx_count = 0;
      return;
    end
    if (rx_count >= need) begin
      cap = max_reg;
      if (cap > STORE_DEPTH) cap = STORE_DEPTH;
      if (cap > MAX_RESULTS) cap = MAX_RESULTS;
      // only a frame with the right tail that fits the cap goes out
      if (b == tail_reg && need <= cap) begin
        for (int k = 0; k < need; k++) begin
          beat.fbyte = store_img[k];
          beat.flen  = need[LEN_W-1:0];
          beat.flast = (k + 1 == need);
          pending_beats.push_back(beat);
        end
      end
      rx_count = 0;
    end
    // a runaway count resyncs after the completion check
    if (rx_count >= RESYNC_LIMIT) rx_count = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, result check, receiver stall and hang watchdog
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  // Outputs are sampled right at the edge, before any update of this edge lands.
  always @(posedge clk) begin
    frame_beat_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_seen++;
        if (pending_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected frame byte %02h len %0d last %0b",
                                    out_frame_byte, out_frame_length, out_frame_last));
        end else begin
          want = pending_beats.pop_front();
          if (out_frame_byte !== want.fbyte)
            report_mismatch($sformatf("frame_byte got %02h want %02h",
                                      out_frame_byte, want.fbyte));
          if (out_frame_length !== want.flen)
            report_mismatch($sformatf("frame_length got %0d want %0d",
                                      out_frame_length, want.flen));
          if (out_frame_last !== want.flast)
            report_mismatch($sformatf("frame_last got %0b want %0b",
                                      out_frame_last, want.flast));
          if (want.flast) frames_seen++;
        end
        hold_left = $urandom_range(0, out_gap_max);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (hold_left != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("[%0t] hang: no progress for %0d cycles, %0d bytes still pending",
                 $realtime, idle_cycles, pending_beats.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One rx byte: optional idle gap, then hold valid until the block takes it.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_byte(b);
    items_sent++;
  endtask

  // Drop valid and hold off until every queued frame byte has come out,
  // then let the readout settle before anything else happens.
  task automatic drain_frames();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write (setup + access), then read back and check the masked value.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] kept;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_HEAD:      head_reg = value[BYTE_W-1:0];
      REG_TAIL:      tail_reg = value[BYTE_W-1:0];
      REG_MAX_FRAME: max_reg  = value[LEN_W-1:0];
      default: ;
    endcase
    reg_writes++;
    case (idx)
      REG_HEAD:      kept = 32'(head_reg);
      REG_TAIL:      kept = 32'(tail_reg);
      default:       kept = 32'(max_reg);
    endcase
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== kept)
      report_mismatch($sformatf("register %s read %08h want %08h", idx.name(), prdata, kept));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Whole frame: head, length LE, random payload, tail (or a corrupted tail).
  task automatic send_frame(input int len, input bit good_tail);
    send_byte(head_reg);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    repeat (len) send_byte(BYTE_W'($urandom));
    send_byte(good_tail ? tail_reg : tail_reg ^ BYTE_W'($urandom_range(1, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values, smallest frames, a bad head, a wrong tail and wrapping lengths.
  task automatic test_reset_defaults();
    send_byte(head_reg ^ 8'h01);          // not a head byte, dropped
    send_frame(0, 1'b1);                  // empty payload, 4-byte frame
    send_byte(head_reg);                  // payload at the byte extremes
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(tail_reg);
    send_frame(0, 1'b0);                  // wrong tail
    send_byte(head_reg);                  // length wraps the 16-bit total
    send_byte(8'hFC);
    send_byte(8'hFF);
    send_byte(head_reg);                  // largest length value
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_frame(1, 1'b1);                  // still in sync after the wraps
    drain_frames();
  endtask

  // Register extremes, masking of upper bits, and the size cap at its edges.
  task automatic test_register_extremes();
    write_reg(REG_HEAD, 32'hFFFF_FF00);   // head 0x00
    write_reg(REG_TAIL, 32'h0000_00FF);   // tail 0xFF
    write_reg(REG_MAX_FRAME, 32'h0000_0004);
    send_frame(0, 1'b1);                  // exactly at the cap
    send_frame(1, 1'b1);                  // one over, dropped
    drain_frames();
    write_reg(REG_MAX_FRAME, 32'hFFFF_FF82); // 2 after masking: nothing passes
    write_reg(REG_HEAD, 32'h0000_00FF);
    write_reg(REG_TAIL, 32'h0000_0000);
    send_frame(0, 1'b1);
    drain_frames();
    write_reg(REG_MAX_FRAME, 32'h0000_0040);
    send_frame(0, 1'b1);
    send_frame(2, 1'b1);
    drain_frames();
  endtask

  // Largest emitted frame and the resync count.
  task automatic test_long_frames();
    write_reg(REG_HEAD, 32'(HEAD_RST));
    write_reg(REG_TAIL, 32'(TAIL_RST));
    write_reg(REG_MAX_FRAME, 32'h0000_007F); // cap falls back to the store size
    send_frame(60, 1'b1);                 // 64 bytes out
    send_frame(0, 1'b1);
    // length 300 never completes: count hits the resync limit at 128 bytes
    send_byte(head_reg);
    send_byte(8'h2C);
    send_byte(8'h01);
    repeat (RESYNC_LIMIT - 3) send_byte(BYTE_W'($urandom));
    send_frame(3, 1'b1);                  // picked up right after the resync
    drain_frames();
  endtask

  // Mostly well-formed frames with random content across several register
  // settings, with some noise, bad tails and wrapping lengths mixed in.
  task automatic test_random_traffic();
    int phase_start;
    int r;
    int phase;
    int random_start;
    random_start = items_sent;
    phase = 0;
    while (items_sent - random_start < 40) begin
      drain_frames();
      // register setting for this phase; extremes show up every few phases
      case (phase % 4)
        0: begin
          write_reg(REG_HEAD, $urandom);
          write_reg(REG_TAIL, $urandom);
          write_reg(REG_MAX_FRAME, 32'($urandom_range(4, 64)));
        end
        1: begin
          write_reg(REG_HEAD, 32'h0000_0000);
          write_reg(REG_TAIL, 32'h0000_00FF);
          write_reg(REG_MAX_FRAME, 32'h0000_0040);
        end
        2: begin
          write_reg(REG_HEAD, 32'h0000_00FF);
          write_reg(REG_TAIL, 32'h0000_0000);
          write_reg(REG_MAX_FRAME, 32'h0000_0008);
        end
        default: begin
          write_reg(REG_HEAD, $urandom);
          write_reg(REG_TAIL, $urandom);
          write_reg(REG_MAX_FRAME, 32'h0000_007F);
        end
      endcase
      // some phases run with no idling on one or both sides
      in_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 8;
      out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      phase_start = items_sent;
      while (items_sent - phase_start < 24) begin
        r = $urandom_range(0, 99);
        if (r < 68)      send_frame($urandom_range(0, 12), 1'b1);
        else if (r < 76) send_frame($urandom_range(13, 60), 1'b1);
        else if (r < 80) send_frame($urandom_range(61, 66), 1'b1);
        else if (r < 88) send_frame($urandom_range(0, 12), 1'b0);
        else if (r < 94) repeat ($urandom_range(1, 3))
                           send_byte(head_reg ^ BYTE_W'($urandom_range(1, 255)));
        else begin
          send_byte(head_reg);
          send_byte(BYTE_W'($urandom_range(8'hFC, 8'hFF)));
          send_byte(8'hFF);
        end
        // now and then the sender waits for the readout to empty
        if ($urandom_range(0, 9) == 0) drain_frames();
      end
      phase++;
    end
    in_gap_max  = 8;
    out_gap_max = 8;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_long_frames();
    test_random_traffic();

    drain_frames();
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d rx bytes over %0d register writes; %0d frames (%0d bytes) checked.",
             items_sent, reg_writes, frames_seen, beats_seen);
    $display("Covered bad heads, bad tails, wrapping and oversize lengths, resync.");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", error_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
